FILE: rtl/wsds_pkg.sv
// Shared types and constants for the windowed sample deviation statistics block.
`timescale 1ns / 1ps

package wsds_pkg;

    // Default configuration of the block.
    localparam int DEF_WINDOW      = 8;
    localparam int DEF_CHANNELS    = 16;
    localparam int DEF_SAMPLE_BITS = 12;

    // Fixed field widths of the transfer payloads.
    localparam int CHANNEL_W = 4;
    localparam int SAMPLE_W  = 12;
    localparam int FILLED_W  = 4;
    localparam int VALUE_W   = 12;

    // Saturation limits of the result fields.
    localparam int FILLED_MAX = 15;
    localparam int VALUE_MAX  = 4095;

    typedef struct packed {
        logic [CHANNEL_W-1:0] channel;
        logic [SAMPLE_W-1:0]  sample;
    } sample_t;

    typedef struct packed {
        logic [FILLED_W-1:0] filled;
        logic [VALUE_W-1:0]  mean;
        logic [VALUE_W-1:0]  max_dev;
        logic [VALUE_W-1:0]  std_dev;
    } result_t;

endpackage

FILE: rtl/windowed_sample_deviation_stats.sv
// Top level of the per-channel sliding-window mean and deviation statistics block.
`timescale 1ns / 1ps

// Each accepted sample transfer writes one converter sample into the ring of the
// last WINDOW samples kept for its channel, and then produces exactly one result
// transfer: the fill count of that window, the truncated mean of the held samples,
// the largest absolute deviation from that mean, and the floor square root of the
// truncated mean squared deviation. Channel numbers beyond CHANNELS wrap modulo
// CHANNELS, and only the low SAMPLE_BITS bits of a sample are kept. The block works
// on one item at a time and holds sample_stall high from acceptance until the
// sequencer returns to idle. A finished result waits in the sequencer while the
// previous result is still stalled in the output register. The time an item takes
// is set by the single ring read port, which walks the window twice (once for the
// sum, once for the deviations), and by the one shared compare-and-subtract unit,
// which computes both divisions by the fill count one quotient bit per cycle and
// the square root one root bit per cycle. Once loaded, a result waits in an output
// register, so the next sample can be accepted while the previous result is still
// stalled. The ring itself is not cleared at reset; only the per-channel write
// positions and fill counts are, and the window walks use only the entries already
// written.
module windowed_sample_deviation_stats #(
    parameter int WINDOW      = wsds_pkg::DEF_WINDOW,
    parameter int CHANNELS    = wsds_pkg::DEF_CHANNELS,
    parameter int SAMPLE_BITS = wsds_pkg::DEF_SAMPLE_BITS
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              sample_valid,
    output logic              sample_stall,
    input  wsds_pkg::sample_t sample_data,
    output logic              result_valid,
    input  logic              result_stall,
    output wsds_pkg::result_t result_data
);

    // Derived widths.
    localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam int DEPTH  = CHANNELS * WINDOW;
    localparam int AW     = $clog2(DEPTH);
    localparam int SUMW   = SAMPLE_BITS + CNT_W;
    localparam int SQW    = 2 * SAMPLE_BITS + CNT_W;
    localparam int SQE    = SQW + (SQW % 2);
    localparam int HW     = SQE / 2;
    localparam int RW     = HW + 3;
    localparam int STEP_W = $clog2(SQE + 1);
    localparam int NCH_IN = 2 ** wsds_pkg::CHANNEL_W;

    // Sequencer states, one-hot.
    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_WRITE = 8'b0000_0010,
        ST_SUM   = 8'b0000_0100,
        ST_DIVM  = 8'b0000_1000,
        ST_DEV   = 8'b0001_0000,
        ST_DIVV  = 8'b0010_0000,
        ST_ROOT  = 8'b0100_0000,
        ST_DONE  = 8'b1000_0000
    } state_t;

    state_t                  state_reg, state_next;
    logic [CH_W-1:0]         ch_reg, ch_next;
    logic [SAMPLE_BITS-1:0]  smp_reg, smp_next;
    logic [AW-1:0]           base_reg, base_next;
    logic [CNT_W-1:0]        n_reg, n_next;
    logic [CNT_W-1:0]        idx_reg, idx_next;
    logic                    v1_reg, v1_next;
    logic                    v2_reg, v2_next;
    logic                    v3_reg, v3_next;
    logic [SUMW-1:0]         sum_reg, sum_next;
    logic [SAMPLE_BITS-1:0]  mean_reg, mean_next;
    logic [SAMPLE_BITS-1:0]  dmax_reg, dmax_next;
    logic [SAMPLE_BITS-1:0]  d_reg, d_next;
    logic [2*SAMPLE_BITS-1:0] prod_reg, prod_next;
    logic [SQW-1:0]          sq_reg, sq_next;
    logic [RW-1:0]           rem_reg, rem_next;
    logic [SQE-1:0]          wk_reg, wk_next;
    logic [HW-1:0]           root_reg, root_next;
    logic [STEP_W-1:0]       step_reg, step_next;
    logic                    out_valid_reg, out_valid_next;
    wsds_pkg::result_t       out_reg, out_next;

    // Sample ring and per-channel window bookkeeping.
    logic [SAMPLE_BITS-1:0]  ring [DEPTH];
    logic [SAMPLE_BITS-1:0]  rd_data_reg;
    logic [AW-1:0]           rd_addr;
    logic [AW-1:0]           wr_addr;
    logic                    wr_en;
    logic [CNT_W-1:0]        wpos_reg [CHANNELS];
    logic [CNT_W-1:0]        fill_reg [CHANNELS];
    logic [CNT_W-1:0]        wpos_next;
    logic [CNT_W-1:0]        fill_next;
    logic [CH_W-1:0]         ch_tab [NCH_IN];

    // Shared compare-and-subtract unit.
    logic                    div_mode;
    logic [RW-1:0]           shifted;
    logic [RW-1:0]           operand;
    logic [RW:0]             diff;
    logic                    fits;
    logic [RW-1:0]           rem_step;
    logic [SQE-1:0]          q_new;
    logic [SAMPLE_BITS-1:0]  dev_now;

    // Channel number reduction, worked out at elaboration for every input code.
    for (genvar g = 0; g < NCH_IN; g++)
    begin : g_ch_tab
        assign ch_tab[g] = CH_W'(g % CHANNELS);
    end

    assign sample_stall = (state_reg != ST_IDLE);
    assign result_valid = out_valid_reg;
    assign result_data  = out_reg;

    assign rd_addr = base_reg + AW'(idx_reg);
    assign wr_addr = base_reg + AW'(wpos_reg[ch_reg]);
    assign wr_en   = (state_reg == ST_WRITE);

    // The unit either brings down one dividend bit and tries the divisor, or brings
    // down two radicand bits and tries the partial root times four plus one.
    assign div_mode = (state_reg inside {ST_DIVM, ST_DIVV});
    assign shifted  = div_mode ? {rem_reg[RW-2:0], wk_reg[SQE-1]}
                               : {rem_reg[RW-3:0], wk_reg[SQE-1:SQE-2]};
    assign operand  = div_mode ? RW'(n_reg) : RW'({root_reg, 2'b01});
    assign diff     = {1'b0, shifted} - {1'b0, operand};
    assign fits     = ~diff[RW];
    assign rem_step = fits ? diff[RW-1:0] : shifted;
    assign q_new    = {wk_reg[SQE-2:0], fits};

    assign dev_now = (rd_data_reg >= mean_reg) ? (rd_data_reg - mean_reg)
                                               : (mean_reg - rd_data_reg);

    always_comb
    begin
        state_next     = state_reg;
        ch_next        = ch_reg;
        smp_next       = smp_reg;
        base_next      = base_reg;
        n_next         = n_reg;
        idx_next       = idx_reg;
        v1_next        = 1'b0;
        v2_next        = 1'b0;
        v3_next        = 1'b0;
        sum_next       = sum_reg;
        mean_next      = mean_reg;
        dmax_next      = dmax_reg;
        d_next         = d_reg;
        prod_next      = prod_reg;
        sq_next        = sq_reg;
        rem_next       = rem_reg;
        wk_next        = wk_reg;
        root_next      = root_reg;
        step_next      = step_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg & result_stall;
        wpos_next      = wpos_reg[ch_reg];
        fill_next      = fill_reg[ch_reg];

        case (state_reg)
            ST_IDLE:
            begin
                if (sample_valid)
                begin
                    ch_next    = ch_tab[sample_data.channel];
                    smp_next   = SAMPLE_BITS'(sample_data.sample);
                    base_next  = AW'(ch_tab[sample_data.channel]) * AW'(WINDOW);
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                // The sample lands in the ring this cycle; the window is read after.
                wpos_next = (wpos_reg[ch_reg] == CNT_W'(WINDOW - 1))
                            ? '0 : wpos_reg[ch_reg] + 1'b1;
                fill_next = (fill_reg[ch_reg] == CNT_W'(WINDOW))
                            ? fill_reg[ch_reg] : fill_reg[ch_reg] + 1'b1;
                n_next     = fill_next;
                idx_next   = '0;
                sum_next   = '0;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                v1_next = (idx_reg != n_reg);
                if (idx_reg != n_reg)
                begin
                    idx_next = idx_reg + 1'b1;
                end
                if (v1_reg)
                begin
                    sum_next = sum_reg + SUMW'(rd_data_reg);
                end
                if (idx_reg == n_reg && !v1_reg)
                begin
                    rem_next   = '0;
                    wk_next    = {sum_reg, {(SQE - SUMW){1'b0}}};
                    step_next  = STEP_W'(SUMW);
                    state_next = ST_DIVM;
                end
            end
            ST_DIVM:
            begin
                rem_next  = rem_step;
                wk_next   = q_new;
                step_next = step_reg - 1'b1;
                if (step_reg == STEP_W'(1))
                begin
                    mean_next  = q_new[SAMPLE_BITS-1:0];
                    idx_next   = '0;
                    dmax_next  = '0;
                    sq_next    = '0;
                    state_next = ST_DEV;
                end
            end
            ST_DEV:
            begin
                v1_next = (idx_reg != n_reg);
                v2_next = v1_reg;
                v3_next = v2_reg;
                if (idx_reg != n_reg)
                begin
                    idx_next = idx_reg + 1'b1;
                end
                if (v1_reg)
                begin
                    d_next = dev_now;
                    if (dev_now > dmax_reg)
                    begin
                        dmax_next = dev_now;
                    end
                end
                if (v2_reg)
                begin
                    prod_next = (2 * SAMPLE_BITS)'(d_reg) * (2 * SAMPLE_BITS)'(d_reg);
                end
                if (v3_reg)
                begin
                    sq_next = sq_reg + SQW'(prod_reg);
                end
                if (idx_reg == n_reg && !v1_reg && !v2_reg && !v3_reg)
                begin
                    rem_next   = '0;
                    wk_next    = SQE'(sq_reg);
                    step_next  = STEP_W'(SQE);
                    state_next = ST_DIVV;
                end
            end
            ST_DIVV:
            begin
                rem_next  = rem_step;
                wk_next   = q_new;
                step_next = step_reg - 1'b1;
                if (step_reg == STEP_W'(1))
                begin
                    // The quotient now holds the variance, which the root consumes.
                    rem_next   = '0;
                    root_next  = '0;
                    step_next  = STEP_W'(HW);
                    state_next = ST_ROOT;
                end
            end
            ST_ROOT:
            begin
                rem_next  = rem_step;
                wk_next   = {wk_reg[SQE-3:0], 2'b00};
                root_next = {root_reg[HW-2:0], fits};
                step_next = step_reg - 1'b1;
                if (step_reg == STEP_W'(1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !result_stall)
                begin
                    out_next.filled  = (32'(n_reg) > wsds_pkg::FILLED_MAX)
                                       ? wsds_pkg::FILLED_W'(wsds_pkg::FILLED_MAX)
                                       : wsds_pkg::FILLED_W'(n_reg);
                    out_next.mean    = (32'(mean_reg) > wsds_pkg::VALUE_MAX)
                                       ? wsds_pkg::VALUE_W'(wsds_pkg::VALUE_MAX)
                                       : wsds_pkg::VALUE_W'(mean_reg);
                    out_next.max_dev = (32'(dmax_reg) > wsds_pkg::VALUE_MAX)
                                       ? wsds_pkg::VALUE_W'(wsds_pkg::VALUE_MAX)
                                       : wsds_pkg::VALUE_W'(dmax_reg);
                    out_next.std_dev = (32'(root_reg) > wsds_pkg::VALUE_MAX)
                                       ? wsds_pkg::VALUE_W'(wsds_pkg::VALUE_MAX)
                                       : wsds_pkg::VALUE_W'(root_reg);
                    out_valid_next   = 1'b1;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int c = 0; c < CHANNELS; c++)
            begin
                wpos_reg[c] <= '0;
                fill_reg[c] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            v1_reg        <= v1_next;
            v2_reg        <= v2_next;
            v3_reg        <= v3_next;
            out_valid_reg <= out_valid_next;
            if (wr_en)
            begin
                wpos_reg[ch_reg] <= wpos_next;
                fill_reg[ch_reg] <= fill_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ch_reg   <= ch_next;
        smp_reg  <= smp_next;
        base_reg <= base_next;
        n_reg    <= n_next;
        idx_reg  <= idx_next;
        sum_reg  <= sum_next;
        mean_reg <= mean_next;
        dmax_reg <= dmax_next;
        d_reg    <= d_next;
        prod_reg <= prod_next;
        sq_reg   <= sq_next;
        rem_reg  <= rem_next;
        wk_reg   <= wk_next;
        root_reg <= root_next;
        step_reg <= step_next;
        out_reg  <= out_next;
    end

    // Ring memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ring[wr_addr] <= smp_reg;
        end
        rd_data_reg <= ring[rd_addr];
    end

    // An accepted sample always starts with the ring write.
    a_accept_writes: assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid && !sample_stall |=> state_reg == ST_WRITE)
        else $error("accepted sample did not start the ring write");

    // A result appears only when the sequencer finishes an item.
    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside the finishing step");

    // The window walks always cover between one and WINDOW entries.
    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SUM || state_reg == ST_DEV)
            |-> n_reg != '0 && 32'(n_reg) <= WINDOW && idx_reg <= n_reg)
        else $error("window walk outside the filled entries");

    // The shared unit never runs with an exhausted step count.
    a_step_live: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIVM || state_reg == ST_DIVV || state_reg == ST_ROOT)
            |-> step_reg != '0)
        else $error("iteration count ran out inside the shared unit");

endmodule
